FILE: rtl/core/gemm_transposed_transposed_top_defines.svh
// ----------------------------------------------------------------------------
// gemm_transposed_transposed_top_defines
// Assertion macros for the checker of the block.
// ----------------------------------------------------------------------------
`ifndef GEMM_TRANSPOSED_TRANSPOSED_TOP_DEFINES_SVH
`define GEMM_TRANSPOSED_TRANSPOSED_TOP_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define GTT_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off during reset.
`define GTT_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/gtt_pkg.sv
// ----------------------------------------------------------------------------
// gtt_pkg
// Types and codes shared by the transposed-transposed GEMM block.
// ----------------------------------------------------------------------------
package gtt_pkg;

  localparam int IDX_W  = 3;   // row / column index fields
  localparam int DIM_W  = 4;   // dimension registers
  localparam int VAL_W  = 16;  // Q8.8 element width
  localparam int ACT_W  = 2;
  localparam int CIDX_W = 3;   // configuration register index

  localparam logic [ACT_W-1:0] ACT_WRITE_A = 2'd0;
  localparam logic [ACT_W-1:0] ACT_WRITE_B = 2'd1;
  localparam logic [ACT_W-1:0] ACT_WRITE_C = 2'd2;
  localparam logic [ACT_W-1:0] ACT_COMPUTE = 2'd3;

  localparam logic [CIDX_W-1:0] REG_ROWS_M = 3'd0;
  localparam logic [CIDX_W-1:0] REG_COLS_N = 3'd1;
  localparam logic [CIDX_W-1:0] REG_DEPTH_K = 3'd2;
  localparam logic [CIDX_W-1:0] REG_ALPHA = 3'd3;
  localparam logic [CIDX_W-1:0] REG_BETA = 3'd4;

  typedef struct packed {
    logic [ACT_W-1:0]        action;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [VAL_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic [IDX_W-1:0]        out_row;
    logic [IDX_W-1:0]        out_col;
    logic signed [VAL_W-1:0] out_value;
    logic                    last;
  } out_t;

  // Dimensions already clamped to the array size.
  typedef struct packed {
    logic [DIM_W-1:0]        m;
    logic [DIM_W-1:0]        n;
    logic [DIM_W-1:0]        k;
    logic signed [VAL_W-1:0] alpha;
    logic signed [VAL_W-1:0] beta;
  } cfg_t;

  // Controller to datapath.
  typedef struct packed {
    logic             load;    // store a write item
    logic             rd_ab;   // read A[l][i] and B[j][l]
    logic             rd_c;    // read C[i][j]
    logic             clear;   // zero the accumulator
    logic             mul;     // form the scaled partial products
    logic             fin;     // round, saturate, write back, emit
    logic             last;
    logic [IDX_W-1:0] i;
    logic [IDX_W-1:0] j;
    logic [IDX_W-1:0] l;
  } cmd_t;

endpackage

FILE: rtl/core/gtt_cfg.sv
// ----------------------------------------------------------------------------
// gtt_cfg
// Configuration register file with dimension clamping.
// ----------------------------------------------------------------------------
module gtt_cfg #(
  parameter int MAX_DIM = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [gtt_pkg::CIDX_W-1:0] cfg_index,
  input  logic [gtt_pkg::VAL_W-1:0]  cfg_data,
  output gtt_pkg::cfg_t             cfg
);
  import gtt_pkg::*;

  localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_DIM);

  logic [DIM_W-1:0]        rows_m;
  logic [DIM_W-1:0]        cols_n;
  logic [DIM_W-1:0]        depth_k;
  logic signed [VAL_W-1:0] alpha_gain;
  logic signed [VAL_W-1:0] beta_gain;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_m     <= 4'd8;
      cols_n     <= 4'd8;
      depth_k    <= 4'd8;
      alpha_gain <= 16'sd256;
      beta_gain  <= 16'sd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ROWS_M:  rows_m     <= cfg_data[DIM_W-1:0];
        REG_COLS_N:  cols_n     <= cfg_data[DIM_W-1:0];
        REG_DEPTH_K: depth_k    <= cfg_data[DIM_W-1:0];
        REG_ALPHA:   alpha_gain <= $signed(cfg_data);
        REG_BETA:    beta_gain  <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.m     = (rows_m > DIM_MAX) ? DIM_MAX : rows_m;
    cfg.n     = (cols_n > DIM_MAX) ? DIM_MAX : cols_n;
    cfg.k     = (depth_k > DIM_MAX) ? DIM_MAX : depth_k;
    cfg.alpha = alpha_gain;
    cfg.beta  = beta_gain;
  end

endmodule

FILE: rtl/core/gtt_ctrl.sv
// ----------------------------------------------------------------------------
// gtt_ctrl
// Sequencer: walks C column-major and issues the per-element MAC schedule.
// ----------------------------------------------------------------------------
module gtt_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  gtt_pkg::in_t  item,
  input  gtt_pkg::cfg_t cfg,
  output gtt_pkg::cmd_t cmd
);
  import gtt_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MAC   = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0]       state, state_next;
  logic [IDX_W-1:0] i, i_next;
  logic [IDX_W-1:0] j, j_next;
  logic [IDX_W-1:0] l, l_next;
  logic             accept;
  logic             i_end, j_end, l_end;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign i_end  = ({1'b0, i} == cfg.m - 4'd1);
  assign j_end  = ({1'b0, j} == cfg.n - 4'd1);
  assign l_end  = ({1'b0, l} == cfg.k - 4'd1);

  always_comb begin
    state_next = state;
    i_next     = i;
    j_next     = j;
    l_next     = l;
    cmd        = '0;
    cmd.i      = i;
    cmd.j      = j;
    cmd.l      = l;
    case (state)
      S_IDLE: begin
        cmd.load = accept && (item.action != ACT_COMPUTE);
        if (accept && item.action == ACT_COMPUTE && cfg.m != '0 && cfg.n != '0) begin
          cmd.clear  = 1'b1;
          i_next     = '0;
          j_next     = '0;
          l_next     = '0;
          state_next = (cfg.k == '0) ? S_DRAIN : S_MAC;
        end
      end
      S_MAC: begin
        cmd.rd_ab = 1'b1;
        if (l_end) begin
          l_next     = '0;
          state_next = S_DRAIN;
        end else begin
          l_next = l + 3'd1;
        end
      end
      S_DRAIN: begin
        cmd.rd_c   = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        cmd.fin   = 1'b1;
        cmd.clear = 1'b1;
        cmd.last  = i_end && j_end;
        if (i_end && j_end) begin
          state_next = S_IDLE;
        end else begin
          if (i_end) begin
            i_next = '0;
            j_next = j + 3'd1;
          end else begin
            i_next = i + 3'd1;
          end
          state_next = (cfg.k == '0) ? S_DRAIN : S_MAC;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      i     <= '0;
      j     <= '0;
      l     <= '0;
    end else begin
      state <= state_next;
      i     <= i_next;
      j     <= j_next;
      l     <= l_next;
    end
  end

endmodule

FILE: rtl/core/gtt_dp.sv
// ----------------------------------------------------------------------------
// gtt_dp
// Datapath: A, B and C stores, shared MAC, scaling, rounding and saturation.
// ----------------------------------------------------------------------------
module gtt_dp #(
  parameter int MAX_DIM    = 8,
  parameter int VALUE_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  gtt_pkg::in_t  item,
  input  gtt_pkg::cfg_t cfg,
  input  gtt_pkg::cmd_t cmd,
  output logic          result_valid,
  output gtt_pkg::out_t result
);
  import gtt_pkg::*;

  localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int AW    = 2 * IW;
  localparam int DEPTH = 1 << AW;
  localparam int CV_W  = (VALUE_BITS > VAL_W) ? VALUE_BITS : VAL_W;
  localparam int SUM_W = 33 + IW;          // up to 2^IW products of 2^30
  localparam int HI_W  = SUM_W - 17;
  localparam int PH_W  = VAL_W + HI_W;
  localparam int PL_W  = VAL_W + 18;
  localparam int PC_W  = VAL_W + CV_W;
  localparam int TA_W  = SUM_W + VAL_W;
  localparam int TC_W  = CV_W + 24;
  localparam int ACC_W = ((TA_W > TC_W) ? TA_W : TC_W) + 2;
  localparam int SH_W  = ACC_W - 16;
  localparam logic signed [SH_W-1:0] SAT_HI =
    SH_W'((longint'(1) <<< (VALUE_BITS - 1)) - longint'(1));
  localparam logic signed [SH_W-1:0] SAT_LO = ~SAT_HI;

  logic [VAL_W-1:0] mem_a [DEPTH];
  logic [VAL_W-1:0] mem_b [DEPTH];
  logic [CV_W-1:0]  mem_c [DEPTH];

  logic signed [VAL_W-1:0] a_q, b_q;
  logic signed [CV_W-1:0]  c_q;
  logic                    ab_valid;
  logic signed [SUM_W-1:0] sum;
  logic signed [PH_W-1:0]  p_hi;
  logic signed [PL_W-1:0]  p_lo;
  logic signed [PC_W-1:0]  p_c;

  logic [AW-1:0]           wr_addr, ra_addr, rb_addr, rc_addr;
  logic                    wr_ok;
  logic signed [31:0]      prod;
  logic signed [HI_W-1:0]  sum_hi;
  logic signed [17:0]      sum_lo;
  logic signed [ACC_W-1:0] acc;
  logic signed [SH_W-1:0]  shifted, clamped;
  logic signed [VALUE_BITS-1:0] res;
  logic signed [CV_W-1:0]  res_c;

  assign wr_addr = {item.row[IW-1:0], item.col[IW-1:0]};
  assign ra_addr = {cmd.l[IW-1:0], cmd.i[IW-1:0]};
  assign rb_addr = {cmd.j[IW-1:0], cmd.l[IW-1:0]};
  assign rc_addr = {cmd.i[IW-1:0], cmd.j[IW-1:0]};
  assign wr_ok   = cmd.load && (int'(item.row) < MAX_DIM) && (int'(item.col) < MAX_DIM);

  always_ff @(posedge clk) begin
    if (wr_ok && item.action == ACT_WRITE_A) mem_a[wr_addr] <= item.value;
    if (cmd.rd_ab) a_q <= mem_a[ra_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_ok && item.action == ACT_WRITE_B) mem_b[wr_addr] <= item.value;
    if (cmd.rd_ab) b_q <= mem_b[rb_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_ok && item.action == ACT_WRITE_C) begin
      mem_c[wr_addr] <= CV_W'(item.value);
    end else if (cmd.fin) begin
      mem_c[rc_addr] <= res_c;
    end
    if (cmd.rd_c) c_q <= mem_c[rc_addr];
  end

  // Exact Q16.16 accumulation, one product per cycle
  assign prod = a_q * b_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      ab_valid <= 1'b0;
    end else begin
      ab_valid <= cmd.rd_ab;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      sum <= '0;
    end else if (ab_valid) begin
      sum <= sum + SUM_W'(prod);
    end
  end

  // alpha * sum split in two narrow products; beta term skipped when beta is 0
  assign sum_hi = sum[SUM_W-1:17];
  assign sum_lo = $signed({1'b0, sum[16:0]});

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      p_hi <= cfg.alpha * sum_hi;
      p_lo <= cfg.alpha * sum_lo;
      if (cfg.beta == '0) begin
        p_c <= '0;
      end else begin
        p_c <= cfg.beta * c_q;
      end
    end
  end

  // Q24.24 sum, floor to Q8.8, saturate
  always_comb begin
    acc = (ACC_W'(p_hi) <<< 17) + ACC_W'(p_lo) + (ACC_W'(p_c) <<< 8);
    shifted = acc[ACC_W-1:16];
    if (shifted > SAT_HI) begin
      clamped = SAT_HI;
    end else if (shifted < SAT_LO) begin
      clamped = SAT_LO;
    end else begin
      clamped = shifted;
    end
    res   = clamped[VALUE_BITS-1:0];
    res_c = CV_W'(res);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.fin;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      result.out_row   <= cmd.i;
      result.out_col   <= cmd.j;
      result.out_value <= res_c[VAL_W-1:0];
      result.last      <= cmd.last;
    end
  end

endmodule

FILE: rtl/core/gemm_transposed_transposed_top.sv
// ----------------------------------------------------------------------------
// gemm_transposed_transposed_top
// C = alpha * A^T * B^T + beta * C on signed Q8.8 data, streamed out.
// ----------------------------------------------------------------------------
// Usage
//   Item channel: a transaction is taken on a rising edge with start high and
//   busy low. Actions 0..2 write one element of A (row l, col i), B (row j,
//   col l) or C (row i, col j), and busy stays low.
//   Action 3 computes the new C from the clamped M, N, K and the gains.
//   Configuration channel: cfg_index / cfg_data, written when cfg_valid and
//   cfg_ready are high; cfg_ready is always high. Write only while idle.
//   Results: one C element per result_valid pulse, column j outer, row i
//   inner, last set on the final one. The receiver cannot stall: each
//   result is on the port for exactly one cycle.
//   Schedule: each element takes K reads into the single
//   multiply-accumulate, a drain, a scaling multiply and a rounding step.
//   busy stays high from the compute transaction until the last element's
//   rounding step; each strobe comes in the cycle after its element's
//   rounding step.
//   With M or N zero nothing is emitted and busy stays low.
//   Reset: rst (synchronous) restores M=N=K=8, alpha=1.0, beta=0 and idles
//   the sequencer. Store contents are undefined until written; there is no
//   clearing pass.
// ----------------------------------------------------------------------------
module gemm_transposed_transposed_top #(
  parameter int MAX_DIM    = 8,
  parameter int VALUE_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  // item channel
  input  logic                       start,
  output logic                       busy,
  input  gtt_pkg::in_t               item,
  // configuration channel
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [gtt_pkg::CIDX_W-1:0] cfg_index,
  input  logic [gtt_pkg::VAL_W-1:0]  cfg_data,
  // results
  output logic                       result_valid,
  output gtt_pkg::out_t              result
);
  import gtt_pkg::*;

  cfg_t cfg;   // clamped dimensions and gains
  cmd_t cmd;   // sequencer commands into the datapath

  gtt_cfg #(
    .MAX_DIM (MAX_DIM)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Sequencer: owns busy and the i/j/l walk
  gtt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .item  (item),
    .cfg   (cfg),
    .cmd   (cmd)
  );

  // Stores, MAC, scaling and the registered result port
  gtt_dp #(
    .MAX_DIM    (MAX_DIM),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cfg          (cfg),
    .cmd          (cmd),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

FILE: rtl/core/gtt_checker.sv
// ----------------------------------------------------------------------------
// gtt_checker
// Port-level checks on the GEMM block, bound to the top level.
// ----------------------------------------------------------------------------
`include "gemm_transposed_transposed_top_defines.svh"

module gtt_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       start,
  input logic                       busy,
  input gtt_pkg::in_t               item,
  input logic                       cfg_valid,
  input logic                       cfg_ready,
  input logic [gtt_pkg::CIDX_W-1:0] cfg_index,
  input logic [gtt_pkg::VAL_W-1:0]  cfg_data,
  input logic                       result_valid,
  input gtt_pkg::out_t              result
);
  import gtt_pkg::*;

  logic load_accept;
  assign load_accept = start && !busy && (item.action != ACT_COMPUTE);

  `GTT_ASSERT_NEXT(a_load_no_busy, clk, rst, load_accept, !busy, "load transaction raised busy")
  `GTT_ASSERT_NOW(a_result_after_busy, clk, rst, result_valid, $past(busy), "result without compute")
  `GTT_ASSERT_NEXT(a_results_spaced, clk, rst, result_valid, !result_valid, "back-to-back results")
  `GTT_ASSERT_NOW(a_last_idle, clk, rst, result_valid && result.last, !busy, "busy after last result")

endmodule

bind gemm_transposed_transposed_top gtt_checker u_gtt_checker (.*);

FILE: sim/tb_gemm_transposed_transposed_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_gemm_transposed_transposed_top
// Self-checking bench for the transposed-transposed GEMM block. It loads A, B
// and C through the item channel, retunes dimensions and gains between
// phases, and compares every streamed C element against an in-bench model of
// C = alpha * A^T * B^T + beta * C or a hand-worked answer.
// ----------------------------------------------------------------------------
module tb_gemm_transposed_transposed_top;
  import gtt_pkg::*;

  localparam int MAX_DIM       = 8;
  localparam int RAND_ITEMS    = 250;        // item transactions after the directed rows
  localparam int SETTLE_CYCLES = 16;         // covers the deepest element's schedule
  localparam int MAX_REPORTS   = 40;
  localparam int TIMEOUT_NS    = 20_000_000;
  localparam longint Q_MAX     = 32767;
  localparam longint Q_MIN     = -32768;

  // Directed rows: either a register write or one item transaction, the
  // latter optionally carrying a hand-worked 1x1 answer.
  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    logic [CIDX_W-1:0]  reg_idx;
    logic [VAL_W-1:0]   reg_val;
    in_t                txn;
    logic               typed;
    out_t               want;
  } dir_row_t;

  logic              clk;
  logic              rst       = 1'b1;
  logic              start     = 1'b0;
  in_t               item      = '0;
  logic              cfg_valid = 1'b0;
  logic [CIDX_W-1:0] cfg_index = '0;
  logic [VAL_W-1:0]  cfg_data  = '0;
  logic              busy;
  logic              cfg_ready;
  logic              result_valid;
  out_t              result;

  // Bench copy of the block: stores, "has been written" flags and registers.
  logic signed [VAL_W-1:0] a_mem [64];
  logic signed [VAL_W-1:0] b_mem [64];
  logic signed [VAL_W-1:0] c_mem [64];
  bit                      a_seen [64];
  bit                      b_seen [64];
  bit                      c_seen [64];
  logic [DIM_W-1:0]        rows_cfg  = 4'd8;
  logic [DIM_W-1:0]        cols_cfg  = 4'd8;
  logic [DIM_W-1:0]        depth_cfg = 4'd8;
  logic signed [VAL_W-1:0] alpha_cfg = 16'sh0100;
  logic signed [VAL_W-1:0] beta_cfg  = 16'sh0000;

  out_t     new_c_elems [$];   // output of the last prediction
  out_t     c_elems_due [$];   // C elements still to arrive, oldest first
  out_t     due_head;
  dir_row_t dir_rows [$];

  int n_items    = 0;
  int n_computes = 0;
  int n_results  = 0;
  int n_phases   = 0;
  int n_errors   = 0;
  int burst_left = 5;
  bit drained_once = 1'b0;

  gemm_transposed_transposed_top DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  function automatic int unsigned dim_eff(input logic [DIM_W-1:0] d);
    return (d > MAX_DIM) ? MAX_DIM : d;
  endfunction

  // Applies one accepted item to the bench copy and leaves the C elements it
  // produces in new_c_elems, column j outer, row i inner.
  function automatic void predict_gemm(input in_t it);
    int unsigned m, n, k, i, j, l;
    longint      dot, acc, q;
    out_t        r;
    new_c_elems.delete();
    case (it.action)
      ACT_WRITE_A: begin
        a_mem[{it.row, it.col}]  = it.value;
        a_seen[{it.row, it.col}] = 1'b1;
      end
      ACT_WRITE_B: begin
        b_mem[{it.row, it.col}]  = it.value;
        b_seen[{it.row, it.col}] = 1'b1;
      end
      ACT_WRITE_C: begin
        c_mem[{it.row, it.col}]  = it.value;
        c_seen[{it.row, it.col}] = 1'b1;
      end
      default: begin
        m = dim_eff(rows_cfg);
        n = dim_eff(cols_cfg);
        k = dim_eff(depth_cfg);
        if (m != 0 && n != 0) begin
          for (j = 0; j < n; j++) begin
            for (i = 0; i < m; i++) begin
              // exact Q16.16 dot product, then Q24.24 combination
              dot = 0;
              for (l = 0; l < k; l++)
                dot += longint'(a_mem[l*8 + i]) * longint'(b_mem[j*8 + l]);
              acc = longint'(alpha_cfg) * dot;
              if (beta_cfg != 0)
                acc += longint'(beta_cfg) * longint'(c_mem[i*8 + j]) * 256;
              q = acc >>> 16;                 // round toward minus infinity
              if (q > Q_MAX) q = Q_MAX;
              else if (q < Q_MIN) q = Q_MIN;
              c_mem[i*8 + j]  = q[VAL_W-1:0];
              c_seen[i*8 + j] = 1'b1;
              r.out_row   = i[IDX_W-1:0];
              r.out_col   = j[IDX_W-1:0];
              r.out_value = q[VAL_W-1:0];
              r.last      = (j == n - 1) && (i == m - 1);
              new_c_elems.push_back(r);
            end
          end
        end
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Result checking: the receiver never stalls, so every strobe is a
  // transaction and is matched against the oldest C element due.
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [VAL_W-1:0] want,
                             input logic [VAL_W-1:0] got);
    if (got !== want) begin
      if (n_errors < MAX_REPORTS)
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      n_errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid === 1'b1) begin
      n_results++;
      if (c_elems_due.size() == 0) begin
        if (n_errors < MAX_REPORTS)
          $display("%0t: C element arrived, expected none, got row %0d col %0d value %h last %b",
                   $time, result.out_row, result.out_col, result.out_value, result.last);
        n_errors++;
      end else begin
        due_head = c_elems_due.pop_front();
        check_field("out_row", VAL_W'(due_head.out_row), VAL_W'(result.out_row));
        check_field("out_col", VAL_W'(due_head.out_col), VAL_W'(result.out_col));
        check_field("out_value", due_head.out_value, result.out_value);
        check_field("last", VAL_W'(due_head.last), VAL_W'(result.last));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------
  // Drops start and waits until every C element due has arrived and the
  // sequencer is idle.
  task automatic hold_until_drained();
    start <= 1'b0;
    while (c_elems_due.size() != 0 || busy !== 1'b0) @(posedge clk);
  endtask

  // Register writes only happen with the block idle, plus a settling margin
  // in case a compute with nothing to emit is still winding down.
  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [VAL_W-1:0] val);
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    case (idx)
      REG_ROWS_M:  rows_cfg  = val[DIM_W-1:0];
      REG_COLS_N:  cols_cfg  = val[DIM_W-1:0];
      REG_DEPTH_K: depth_cfg = val[DIM_W-1:0];
      REG_ALPHA:   alpha_cfg = val;
      REG_BETA:    beta_cfg  = val;
      default: ;
    endcase
  endtask

  // One item transaction. start is left high when the next item follows at
  // once; the caller either sends again or lowers it in the same step.
  task automatic send_item(input in_t it, input bit typed, input out_t want);
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy !== 1'b0);
    predict_gemm(it);
    if (typed) c_elems_due.push_back(want);
    else foreach (new_c_elems[x]) c_elems_due.push_back(new_c_elems[x]);
    n_items++;
    if (it.action == ACT_COMPUTE) n_computes++;
    // bursts of back-to-back items, broken by short gaps
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 50)
                                                : $urandom_range(1, 8);
    end else begin
      burst_left--;
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus generation
  // --------------------------------------------------------------------------
  function automatic logic [VAL_W-1:0] rand_q88();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2, 3: return 16'($urandom);
      default: return 16'($urandom_range(0, 2047) - 1024);
    endcase
  endfunction

  function automatic logic [VAL_W-1:0] gain_word(input bit for_beta);
    if (for_beta && $urandom_range(0, 2) == 0) return 16'h0000;
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'h0100;        // 1.0
      2: return 16'h7FFF;
      3: return 16'h8000;
      4: return 16'hFF00;        // -1.0
      5, 6: return 16'($urandom);
      default: return 16'($urandom_range(0, 1023) - 512);
    endcase
  endfunction

  // Mostly small sizes; values above eight are clamped by the block.
  function automatic logic [VAL_W-1:0] dim_word(input bit big);
    logic [DIM_W-1:0] d;
    if (big) d = $urandom_range(0, 1) ? 4'd8 : 4'd15;
    else begin
      case ($urandom_range(0, 19))
        0: d = 4'd0;
        1: d = 4'($urandom_range(9, 15));
        2, 3, 4: d = 4'($urandom_range(5, 8));
        default: d = 4'($urandom_range(1, 4));
      endcase
    end
    // upper bits are don't-care for the dimension registers
    return {($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'h000, d};
  endfunction

  function automatic in_t make_item(input logic [ACT_W-1:0] act, input int unsigned r,
                                    input int unsigned c, input logic [VAL_W-1:0] v);
    in_t it;
    it.action = act;
    it.row    = r[IDX_W-1:0];
    it.col    = c[IDX_W-1:0];
    it.value  = v;
    return it;
  endfunction

  function automatic logic [ACT_W-1:0] rand_load_action();
    case ($urandom_range(0, 2))
      0: return ACT_WRITE_A;
      1: return ACT_WRITE_B;
      default: return ACT_WRITE_C;
    endcase
  endfunction

  // Writes every element the next compute will use that has never been
  // written (C only when beta is nonzero), so no undefined entry is used.
  task automatic fill_needed();
    int unsigned m, n, k, i, j, l;
    m = dim_eff(rows_cfg);
    n = dim_eff(cols_cfg);
    k = dim_eff(depth_cfg);
    for (l = 0; l < k; l++)
      for (i = 0; i < m; i++)
        if (!a_seen[l*8 + i]) send_item(make_item(ACT_WRITE_A, l, i, rand_q88()), 1'b0, '0);
    for (j = 0; j < n; j++)
      for (l = 0; l < k; l++)
        if (!b_seen[j*8 + l]) send_item(make_item(ACT_WRITE_B, j, l, rand_q88()), 1'b0, '0);
    if (beta_cfg != 0)
      for (i = 0; i < m; i++)
        for (j = 0; j < n; j++)
          if (!c_seen[i*8 + j]) send_item(make_item(ACT_WRITE_C, i, j, rand_q88()), 1'b0, '0);
  endtask

  // One configuration phase: retune some registers, then a few load-and-
  // compute sequences, with stray writes mixed in unless the phase is big.
  task automatic run_phase(input bit big);
    int unsigned seqs, noise;
    n_phases++;
    if (big || $urandom_range(0, 3) != 0) write_reg(REG_ROWS_M, dim_word(big));
    if (big || $urandom_range(0, 3) != 0) write_reg(REG_COLS_N, dim_word(big));
    if (big || $urandom_range(0, 3) != 0) write_reg(REG_DEPTH_K, dim_word(big));
    if (big || $urandom_range(0, 2) != 0) write_reg(REG_ALPHA, gain_word(1'b0));
    if (big) write_reg(REG_BETA, 16'h0000);
    else if ($urandom_range(0, 2) != 0) write_reg(REG_BETA, gain_word(1'b1));
    seqs = $urandom_range(1, 4);
    repeat (seqs) begin
      noise = big ? 0 : $urandom_range(0, 6);
      repeat (noise)
        send_item(make_item(rand_load_action(), $urandom_range(0, 7), $urandom_range(0, 7),
                            rand_q88()), 1'b0, '0);
      fill_needed();
      // now and then let the previous matrix stream out completely first
      if (!drained_once || $urandom_range(0, 4) == 0) begin
        hold_until_drained();
        drained_once = 1'b1;
      end
      send_item(make_item(ACT_COMPUTE, $urandom_range(0, 7), $urandom_range(0, 7),
                          16'($urandom)), 1'b0, '0);
    end
  endtask

  // --------------------------------------------------------------------------
  // Directed rows, 1x1 wherever possible so the answer can be written down
  // --------------------------------------------------------------------------
  function automatic void dir_cfg(input logic [CIDX_W-1:0] idx, input logic [VAL_W-1:0] val);
    dir_row_t r;
    r = '0;
    r.kind    = ROW_CFG;
    r.reg_idx = idx;
    r.reg_val = val;
    dir_rows.push_back(r);
  endfunction

  function automatic void dir_load(input logic [ACT_W-1:0] act, input logic [VAL_W-1:0] v);
    dir_row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.txn  = make_item(act, 0, 0, v);
    dir_rows.push_back(r);
  endfunction

  // typed: the single element (0,0) with the given value and last set
  function automatic void dir_compute(input bit typed, input logic [VAL_W-1:0] v);
    dir_row_t r;
    r = '0;
    r.kind  = ROW_ITEM;
    r.txn   = make_item(ACT_COMPUTE, $urandom_range(0, 7), $urandom_range(0, 7),
                        16'($urandom));
    r.typed = typed;
    r.want  = '{3'd0, 3'd0, v, 1'b1};
    dir_rows.push_back(r);
  endfunction

  function automatic void build_directed();
    dir_cfg(REG_ROWS_M, 16'd1);
    dir_cfg(REG_COLS_N, 16'd1);
    dir_cfg(REG_DEPTH_K, 16'd1);
    // 1.0 times the extremes passes straight through
    dir_load(ACT_WRITE_A, 16'h0100);
    dir_load(ACT_WRITE_B, 16'h7FFF);
    dir_compute(1'b1, 16'h7FFF);
    dir_load(ACT_WRITE_B, 16'h8000);
    dir_compute(1'b1, 16'h8000);
    // saturation both ways
    dir_load(ACT_WRITE_A, 16'h7FFF);
    dir_load(ACT_WRITE_B, 16'h7FFF);
    dir_cfg(REG_ALPHA, 16'h7FFF);
    dir_compute(1'b1, 16'h7FFF);
    dir_load(ACT_WRITE_B, 16'h8000);
    dir_compute(1'b1, 16'h8000);
    dir_cfg(REG_ALPHA, 16'h8000);
    dir_load(ACT_WRITE_A, 16'h8000);
    dir_load(ACT_WRITE_B, 16'h8000);
    dir_compute(1'b1, 16'h8000);
    // zero alpha, zero beta: all zeros
    dir_cfg(REG_ALPHA, 16'h0000);
    dir_compute(1'b1, 16'h0000);
    // zero alpha, beta 1.0: C comes back unchanged
    dir_load(ACT_WRITE_C, 16'h1234);
    dir_cfg(REG_BETA, 16'h0100);
    dir_compute(1'b1, 16'h1234);
    // empty inner dimension, beta 1.0: unchanged again
    dir_cfg(REG_ALPHA, 16'h0100);
    dir_cfg(REG_DEPTH_K, 16'd0);
    dir_compute(1'b1, 16'h1234);
    // beta extremes and rounding down of halves; C feeds back each time
    dir_cfg(REG_BETA, 16'h7FFF);
    dir_compute(1'b1, 16'h7FFF);
    dir_cfg(REG_BETA, 16'h8000);
    dir_compute(1'b1, 16'h8000);
    dir_cfg(REG_BETA, 16'hFF00);
    dir_compute(1'b1, 16'h7FFF);
    dir_cfg(REG_BETA, 16'h0080);
    dir_compute(1'b1, 16'h3FFF);
    dir_cfg(REG_BETA, 16'hFF80);
    dir_compute(1'b1, 16'hE000);
    // empty C: nothing may come out
    dir_cfg(REG_ROWS_M, 16'd0);
    dir_compute(1'b0, 16'h0000);
    dir_cfg(REG_ROWS_M, 16'd1);
    dir_cfg(REG_COLS_N, 16'd0);
    dir_compute(1'b0, 16'h0000);
  endfunction

  // --------------------------------------------------------------------------
  // Run sequence
  // --------------------------------------------------------------------------
  initial begin
    int dir_items;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    build_directed();
    foreach (dir_rows[x]) begin
      if (dir_rows[x].kind == ROW_CFG) write_reg(dir_rows[x].reg_idx, dir_rows[x].reg_val);
      else send_item(dir_rows[x].txn, dir_rows[x].typed, dir_rows[x].want);
    end
    dir_items = n_items;

    // one full-size phase first (fills the A and B stores), then mostly small ones
    run_phase(1'b1);
    while (n_items - dir_items < RAND_ITEMS) run_phase(1'b0);

    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d item transactions, %0d of them computes, over %0d phases;",
             n_items, n_computes, n_phases);
    $display("%0d C elements streamed out, %0d mismatches.", n_results, n_errors);
    if (n_errors == 0) begin
      $display("[gemm_transposed_transposed_top] OK");
    end else begin
      $display("[gemm_transposed_transposed_top] ERROR");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run.
  initial begin
    #(TIMEOUT_NS);
    $display("Timed out with %0d C elements still due.", c_elems_due.size());
    $display("[gemm_transposed_transposed_top] ERROR");
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/gtt_pkg.sv
rtl/core/gtt_cfg.sv
rtl/core/gtt_ctrl.sv
rtl/core/gtt_dp.sv
rtl/core/gemm_transposed_transposed_top.sv
rtl/core/gtt_checker.sv
sim/tb_gemm_transposed_transposed_top.sv
